// ===== sv/fat_chain_allocator_unit_assert.svh =====
// Assertion macros used by the allocator controller
`ifndef FAT_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH
`define FAT_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH

// label, clock, active-low reset, property body, message
`define FCA_ASSERT(lbl, clk_s, rstn_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

`define FCA_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

// ===== sv/fca_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package fca_pkg;
    localparam int SECTORS_DEF = 32;

    localparam logic [2:0] OP_WRITE = 3'd0;
    localparam logic [2:0] OP_READ  = 3'd1;
    localparam logic [2:0] OP_ALLOC = 3'd2;
    localparam logic [2:0] OP_FREE  = 3'd3;
    localparam logic [2:0] OP_WALK  = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FREE   = 3'd1;
    localparam logic [2:0] ST_TOO_FEW    = 3'd2;
    localparam logic [2:0] ST_BAD_SECTOR = 3'd3;
    localparam logic [2:0] ST_BAD_COUNT  = 3'd4;

    typedef struct packed {
        logic [2:0] op;
        logic [4:0] base_sector;
        logic [4:0] chain_length;
        logic [4:0] entry_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic [4:0] sector;
        logic [4:0] table_value;
        logic [4:0] free_count;
        logic       has_free;
        logic [4:0] first_free;
        logic       last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic scan_clr;   // reset scan index to start
        logic scan_step;  // advance scan index
        logic cnt_clr;    // clear available counter
        logic link_step;  // allocate link step
        logic free_step;  // free step
        logic walk_step;  // walk step
        logic wr_entry;   // write entry
        logic sum_clr;    // clear summary pass
        logic sum_step;   // summary pass step
        logic emit;       // load output register
        logic emit_last;
        logic [2:0] emit_status;
        logic emit_zero;  // table_value forced to zero
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] op;
        logic       bad_sector;
        logic       reserved;
        logic       len_zero;
        logic       start_free;
        logic       scan_done;
        logic       enough;
        logic       link_done;
        logic       free_done;
        logic       walk_stop;
        logic       sum_done;
    } dp_stat_t;
endpackage
`default_nettype wire

// ===== sv/fca_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fca_datapath #(
    parameter int SECTORS = fca_pkg::SECTORS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  fca_pkg::in_item_t     in_item,
    input  fca_pkg::dp_cmd_t      cmd,
    output fca_pkg::dp_stat_t     stat,
    output fca_pkg::out_item_t    out_item
);
    import fca_pkg::*;

    localparam int IW = $clog2(SECTORS);
    localparam int CW = $clog2(SECTORS + 1);
    localparam int CAP = (SECTORS < 32) ? SECTORS : 32;

    in_item_t        item_reg;
    logic [4:0]      tbl [SECTORS];
    logic [SECTORS-1:0] wr_seen_reg;     // entries overwritten since reset
    logic [IW-1:0]   idx_reg;            // scan / chain cursor
    logic [CW-1:0]   cnt_reg;            // avail or step counter
    logic [IW-1:0]   prev_reg;
    logic [CW-1:0]   linked_reg;
    logic [4:0]      sfc_reg;            // summary free count
    logic            sany_reg;
    logic [4:0]      sfirst_reg;
    logic [IW-1:0]   sidx_reg;
    logic            sdone_reg;

    // table entry read as a function: reset value until written
    function automatic logic [4:0] rd(input logic [IW-1:0] a,
                                      input logic [SECTORS-1:0] seen,
                                      input logic [4:0] v);
        logic [4:0] r;
        if (seen[a])
            r = v;
        else
            r = (a < IW'(2)) ? 5'd0 : 5'd1;
        return r;
    endfunction

    logic [4:0] cur_val;
    logic [4:0] sum_val;
    logic [4:0] start_val;
    logic [IW-1:0] start_i;

    assign start_i   = IW'(item_reg.base_sector);
    assign cur_val   = rd(idx_reg, wr_seen_reg, tbl[idx_reg]);
    assign sum_val   = rd(sidx_reg, wr_seen_reg, tbl[sidx_reg]);
    assign start_val = rd(start_i, wr_seen_reg, tbl[start_i]);

    logic cur_free, cur_link;
    assign cur_free = (cur_val == 5'd1);
    assign cur_link = (cur_val >= 5'd2) && (int'(cur_val) < SECTORS);

    // table writes: one port
    logic          we;
    logic [IW-1:0] wa;
    logic [4:0]    wd;
    always_comb
    begin
        we = 1'b0;
        wa = idx_reg;
        wd = 5'd0;
        if (cmd.wr_entry)
        begin
            we = 1'b1; wa = start_i; wd = item_reg.entry_value;
        end
        else if (cmd.free_step)
        begin
            we = 1'b1; wa = idx_reg; wd = 5'd1;
        end
        else if (cmd.link_step)
        begin
            if (linked_reg == CW'(item_reg.chain_length))
            begin
                we = 1'b1; wa = prev_reg; wd = 5'd0;
            end
            else if (cur_free && idx_reg != prev_reg)
            begin
                we = 1'b1; wa = prev_reg; wd = 5'(idx_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            tbl[wa] <= wd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_seen_reg <= '0;
        else if (we)
            wr_seen_reg[wa] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            item_reg <= in_item;
        if (cmd.scan_clr)
        begin
            idx_reg    <= IW'(item_reg.base_sector);
            prev_reg   <= IW'(item_reg.base_sector);
            linked_reg <= CW'(1);
        end
        else if (cmd.scan_step)
            idx_reg <= idx_reg + IW'(1);
        else if (cmd.link_step)
        begin
            if (cur_free && idx_reg != prev_reg)
            begin
                prev_reg   <= idx_reg;
                linked_reg <= linked_reg + CW'(1);
            end
            idx_reg <= idx_reg + IW'(1);
        end
        else if (cmd.free_step || cmd.walk_step)
            idx_reg <= IW'(cur_val);
        if (cmd.cnt_clr)
            cnt_reg <= '0;
        else if (cmd.scan_step)
            cnt_reg <= cnt_reg + CW'(cur_free);
        else if (cmd.free_step || cmd.walk_step)
            cnt_reg <= cnt_reg + CW'(1);
        if (cmd.sum_clr)
        begin
            sidx_reg <= IW'(2); sfc_reg <= '0; sany_reg <= 1'b0;
            sfirst_reg <= '0; sdone_reg <= 1'b0;
        end
        else if (cmd.sum_step && !sdone_reg)
        begin
            if (sum_val == 5'd1)
            begin
                sfc_reg <= sfc_reg + 5'd1;
                if (!sany_reg)
                begin
                    sany_reg <= 1'b1; sfirst_reg <= 5'(sidx_reg);
                end
            end
            if (sidx_reg == IW'(SECTORS - 1))
                sdone_reg <= 1'b1;
            else
                sidx_reg <= sidx_reg + IW'(1);
        end
    end

    // availability scan ends at the top entry
    logic scan_first_done;
    assign scan_first_done = (idx_reg == IW'(SECTORS - 1));

    always_comb
    begin
        stat.op         = item_reg.op;
        stat.bad_sector = (item_reg.op > OP_WALK)
                        || (int'(item_reg.base_sector) >= SECTORS);
        stat.reserved   = (item_reg.base_sector < 5'd2);
        stat.len_zero   = (item_reg.chain_length == 5'd0);
        stat.start_free = (start_val == 5'd1);
        stat.scan_done  = scan_first_done;
        stat.enough     = (cnt_reg >= CW'(item_reg.chain_length));
        stat.link_done  = (linked_reg == CW'(item_reg.chain_length));
        stat.free_done  = !cur_link || (cnt_reg == CW'(SECTORS - 1));
        stat.walk_stop  = !cur_link || (cnt_reg == CW'(CAP - 1));
        stat.sum_done   = sdone_reg;
    end

    // walk captures the sector/value before advancing
    logic [4:0] walk_sec_reg, walk_val_reg;
    always_ff @(posedge clk)
    begin
        if (cmd.walk_step)
        begin
            walk_sec_reg <= 5'(idx_reg);
            walk_val_reg <= cur_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item.status      <= cmd.emit_status;
            out_item.sector      <= (item_reg.op == OP_WALK && !stat.bad_sector)
                                  ? walk_sec_reg : item_reg.base_sector;
            out_item.table_value <= cmd.emit_zero ? 5'd0
                                  : (item_reg.op == OP_WALK) ? walk_val_reg : start_val;
            out_item.free_count  <= sfc_reg;
            out_item.has_free    <= sany_reg;
            out_item.first_free  <= sfirst_reg;
            out_item.last        <= cmd.emit_last;
        end
    end
endmodule
`default_nettype wire

// ===== sv/fca_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module fca_ctrl (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    input  fca_pkg::dp_stat_t stat,
    output fca_pkg::dp_cmd_t  cmd
);
    import fca_pkg::*;
    `include "fat_chain_allocator_unit_assert.svh"

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DEC   = 4'd1;
    localparam logic [3:0] S_SCAN  = 4'd2;
    localparam logic [3:0] S_LINKI = 4'd3;
    localparam logic [3:0] S_LINK  = 4'd4;
    localparam logic [3:0] S_FREE  = 4'd5;
    localparam logic [3:0] S_WALK  = 4'd6;
    localparam logic [3:0] S_SUM   = 4'd7;
    localparam logic [3:0] S_EMIT  = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic [2:0] st_reg, st_next;
    logic       zero_reg, zero_next;
    logic       last_reg, last_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        st_next    = st_reg;
        zero_next  = zero_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.emit_status = st_reg;
        cmd.emit_zero   = zero_reg;
        cmd.emit_last   = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                cmd.scan_clr = 1'b1;
                cmd.cnt_clr  = 1'b1;
                st_next = ST_OK; zero_next = 1'b0; last_next = 1'b1;
                state_next = S_SUM;
                if (stat.bad_sector)
                begin
                    st_next = ST_BAD_SECTOR; zero_next = 1'b1;
                end
                else
                begin
                    case (stat.op)
                        OP_WRITE: cmd.wr_entry = 1'b1;
                        OP_READ: ;
                        OP_ALLOC:
                        begin
                            if (stat.reserved)
                            begin
                                st_next = ST_BAD_SECTOR; zero_next = 1'b1;
                            end
                            else if (stat.len_zero)
                                st_next = ST_BAD_COUNT;
                            else if (!stat.start_free)
                                st_next = ST_NOT_FREE;
                            else
                                state_next = S_SCAN;
                        end
                        OP_FREE:
                        begin
                            if (stat.reserved)
                            begin
                                st_next = ST_BAD_SECTOR; zero_next = 1'b1;
                            end
                            else
                                state_next = S_FREE;
                        end
                        OP_WALK: state_next = S_WALK;
                        default: ;
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done)
                    state_next = S_LINKI;
            end
            S_LINKI:
            begin
                // count is complete; rewind to start
                if (!stat.enough)
                begin
                    st_next = ST_TOO_FEW;
                    state_next = S_SUM;
                end
                else
                begin
                    cmd.scan_clr = 1'b1;
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                cmd.link_step = 1'b1;
                if (stat.link_done)
                    state_next = S_SUM;
            end
            S_FREE:
            begin
                cmd.free_step = 1'b1;
                if (stat.free_done)
                    state_next = S_SUM;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                last_next = stat.walk_stop;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_clr = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                cmd.sum_step = 1'b1;
                if (stat.sum_done && !valid_reg)
                begin
                    cmd.emit = 1'b1;
                    valid_next = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    if (last_reg)
                        state_next = S_IDLE;
                    else
                        state_next = S_WALK;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            st_reg    <= ST_OK;
            zero_reg  <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            st_reg    <= st_next;
            zero_reg  <= zero_next;
            last_reg  <= last_next;
        end
    end

    `FCA_ASSERT(a_out_only_in_out, clk, rst_n, out_valid |-> state_reg == S_OUT, "out_valid outside output state")
    `FCA_ASSERT(a_no_accept_busy, clk, rst_n, in_ready |-> !out_valid, "input taken while result pending")
    `FCA_ASSERT(a_load_to_dec, clk, rst_n, (in_valid && in_ready) |=> state_reg == S_DEC, "accept did not start decode")
endmodule
`default_nettype wire

// ===== sv/fat_chain_allocator_unit.sv =====
// Sector allocation table unit.
// Each item passes decode, its operation's steps and a summary pass before
// its result; a walk gives one result per chain entry visited, each further
// result following the transfer of the one before.
// Throughput: one item at a time; the next is accepted only after the final transfer.
// Reset (rst_n, async low): table reads as entries 0,1 zero and others free.
`timescale 1ns / 1ps
`default_nettype none
module fat_chain_allocator_unit #(
    parameter int SECTORS = fca_pkg::SECTORS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  fca_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output fca_pkg::out_item_t out_data
);
    import fca_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    fca_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready),
        .stat(stat), .cmd(cmd)
    );

    fca_datapath #(.SECTORS(SECTORS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .in_item(in_data), .cmd(cmd), .stat(stat), .out_item(out_data)
    );
endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import fca_pkg::*;

    localparam int NSEC = 32;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;

    fat_chain_allocator_unit #(.SECTORS(NSEC)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    // predictor state
    logic [4:0] sec_map [NSEC];
    out_item_t pending_results [$];
    int n_errors;
    int n_items;
    int n_results;
    bit src_idle_en;
    bit sink_idle_en;
    bit sink_hold;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #100ms;
        $display("TIMEOUT");
        $display("fat_chain_allocator_unit verification failed");
        $finish;
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        n_errors++;
        $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    function automatic out_item_t make_result(input logic [2:0] st, input logic [4:0] sec,
                                              input logic [4:0] val, input bit fin);
        out_item_t r;
        int cnt;
        cnt = 0;
        r.first_free = '0;
        for (int i = NSEC - 1; i >= 2; i--)
        begin
            if (sec_map[i] == 5'd1)
            begin
                cnt++;
                r.first_free = i[4:0];
            end
        end
        r.status = st;
        r.sector = sec;
        r.table_value = val;
        r.free_count = cnt[4:0];
        r.has_free = (cnt != 0);
        r.last = fin;
        return r;
    endfunction

    task automatic predict_chain_op(input in_item_t it);
        logic [4:0] s;
        logic [4:0] cur;
        logic [4:0] nxt;
        logic [4:0] prev;
        int avail;
        int linked;
        logic [2:0] st;
        bit stop;
        s = it.base_sector;
        case (it.op)
            OP_WRITE:
            begin
                sec_map[s] = it.entry_value;
                pending_results.push_back(make_result(ST_OK, s, sec_map[s], 1'b1));
            end
            OP_READ: pending_results.push_back(make_result(ST_OK, s, sec_map[s], 1'b1));
            OP_ALLOC:
            begin
                if (s < 2)
                    pending_results.push_back(make_result(ST_BAD_SECTOR, s, 5'd0, 1'b1));
                else
                begin
                    avail = 0;
                    for (int i = int'(s); i < NSEC; i++)
                        if (sec_map[i] == 5'd1) avail++;
                    if (it.chain_length == 0) st = ST_BAD_COUNT;
                    else if (sec_map[s] != 5'd1) st = ST_NOT_FREE;
                    else if (avail < it.chain_length) st = ST_TOO_FEW;
                    else
                    begin
                        st = ST_OK;
                        prev = s;
                        linked = 1;
                        for (int i = int'(s) + 1; i < NSEC && linked < it.chain_length; i++)
                        begin
                            if (sec_map[i] == 5'd1)
                            begin
                                sec_map[prev] = i[4:0];
                                prev = i[4:0];
                                linked++;
                            end
                        end
                        sec_map[prev] = 5'd0;
                    end
                    pending_results.push_back(make_result(st, s, sec_map[s], 1'b1));
                end
            end
            OP_FREE:
            begin
                if (s < 2)
                    pending_results.push_back(make_result(ST_BAD_SECTOR, s, 5'd0, 1'b1));
                else
                begin
                    cur = s;
                    for (int k = 0; k < NSEC; k++)
                    begin
                        nxt = sec_map[cur];
                        sec_map[cur] = 5'd1;
                        if (nxt < 2) break;
                        cur = nxt;
                    end
                    pending_results.push_back(make_result(ST_OK, s, sec_map[s], 1'b1));
                end
            end
            OP_WALK:
            begin
                cur = s;
                for (int k = 0; k < NSEC; k++)
                begin
                    nxt = sec_map[cur];
                    stop = (nxt < 2) || (k + 1 >= NSEC);
                    pending_results.push_back(make_result(ST_OK, cur, nxt, stop));
                    if (stop) break;
                    cur = nxt;
                end
            end
            default: pending_results.push_back(make_result(ST_BAD_SECTOR, s, 5'd0, 1'b1));
        endcase
    endtask

    // sender: drive at falling edge, hold until accepted; valid stays up between items unless an idle gap is inserted
    task automatic send_item(input logic [2:0] op, input logic [4:0] s,
                             input logic [4:0] n, input logic [4:0] v);
        in_item_t it;
        int gap;
        it.op = op;
        it.base_sector = s;
        it.chain_length = n;
        it.entry_value = v;
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 7);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predict_chain_op(it);
        n_items++;
        @(negedge clk);
    endtask

    // receiver ready
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold)
                out_ready <= 1'b0;
            else if (sink_idle_en && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 7) - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // result checker
    initial
    begin
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                n_results++;
                if (pending_results.size() == 0)
                    report("unexpected result", 32'(out_data), 32'd0);
                else
                begin
                    want = pending_results.pop_front();
                    if (out_data.status != want.status)
                        report("status", 32'(out_data.status), 32'(want.status));
                    if (out_data.sector != want.sector)
                        report("sector", 32'(out_data.sector), 32'(want.sector));
                    if (out_data.table_value != want.table_value)
                        report("table_value", 32'(out_data.table_value),
                               32'(want.table_value));
                    if (out_data.free_count != want.free_count)
                        report("free_count", 32'(out_data.free_count), 32'(want.free_count));
                    if (out_data.has_free != want.has_free)
                        report("has_free", 32'(out_data.has_free), 32'(want.has_free));
                    if (out_data.first_free != want.first_free)
                        report("first_free", 32'(out_data.first_free), 32'(want.first_free));
                    if (out_data.last != want.last)
                        report("last", 32'(out_data.last), 32'(want.last));
                end
            end
        end
    end

    task automatic test_directed();
        send_item(OP_READ, 5'd0, 5'd0, 5'd0);
        send_item(OP_READ, 5'd31, 5'd31, 5'd31);
        send_item(OP_ALLOC, 5'd0, 5'd3, 5'd0);
        send_item(OP_ALLOC, 5'd1, 5'd3, 5'd0);
        send_item(OP_ALLOC, 5'd4, 5'd0, 5'd0);
        send_item(OP_ALLOC, 5'd4, 5'd5, 5'd0);
        send_item(OP_WALK, 5'd4, 5'd0, 5'd0);
        send_item(OP_ALLOC, 5'd5, 5'd2, 5'd0);
        send_item(OP_ALLOC, 5'd30, 5'd3, 5'd0);
        send_item(OP_ALLOC, 5'd20, 5'd12, 5'd0);
        send_item(OP_FREE, 5'd4, 5'd0, 5'd0);
        send_item(OP_FREE, 5'd4, 5'd0, 5'd0);
        send_item(OP_FREE, 5'd0, 5'd0, 5'd0);
        send_item(OP_FREE, 5'd1, 5'd0, 5'd0);
        send_item(3'd5, 5'd3, 5'd0, 5'd0);
        send_item(3'd7, 5'd31, 5'd31, 5'd31);
        send_item(OP_ALLOC, 5'd2, 5'd30, 5'd0);
        send_item(OP_WALK, 5'd2, 5'd0, 5'd0);
        send_item(OP_ALLOC, 5'd2, 5'd31, 5'd0);
        send_item(OP_WRITE, 5'd31, 5'd0, 5'd2);
        send_item(OP_WALK, 5'd2, 5'd0, 5'd0);
        send_item(OP_FREE, 5'd2, 5'd0, 5'd0);
        send_item(OP_WRITE, 5'd0, 5'd0, 5'd31);
        send_item(OP_WALK, 5'd0, 5'd0, 5'd0);
        send_item(OP_WRITE, 5'd0, 5'd0, 5'd0);
    endtask

    // mostly allocate/walk/free, plus reads, writes and bad ops
    task automatic test_random(input int count);
        logic [2:0] op;
        logic [4:0] s;
        int pick;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            s = (pick < 70) ? 5'($urandom_range(2, 31)) : 5'($urandom_range(0, 31));
            if (pick < 30) op = OP_ALLOC;
            else if (pick < 50) op = OP_WALK;
            else if (pick < 68) op = OP_FREE;
            else if (pick < 80) op = OP_READ;
            else if (pick < 95) op = OP_WRITE;
            else op = 3'($urandom_range(5, 7));
            send_item(op, s,
                      (pick % 4 == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6)),
                      5'($urandom_range(0, 31)));
        end
    endtask

    task automatic test_backpressure();
        int hold;
        hold = 400;
        sink_hold = 1'b1;
        fork
            begin
                repeat (hold) @(posedge clk);
                sink_hold = 1'b0;
            end
            test_random(12);
        join
    endtask

    initial
    begin
        int drain;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        n_errors = 0;
        n_items = 0;
        n_results = 0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        sink_hold = 1'b0;
        for (int i = 0; i < NSEC; i++)
            sec_map[i] = (i < 2) ? 5'd0 : 5'd1;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(300);
        test_backpressure();
        test_random(120);
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        test_random(60);
        in_valid <= 1'b0;
        drain = 0;
        while (pending_results.size() != 0 && drain < 200000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (300) @(posedge clk);
        if (pending_results.size() != 0)
            report("results still outstanding", 32'(pending_results.size()), 32'd0);
        $display("Sent %0d items covering write, read, allocate, free, walk and bad ops;",
                 n_items);
        $display("checked %0d results with random idling and a long receiver stall.", n_results);
        if (n_errors == 0)
            $display("fat_chain_allocator_unit verification clean");
        else
            $display("fat_chain_allocator_unit verification failed");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+sv
sv/fca_pkg.sv
sv/fca_datapath.sv
sv/fca_ctrl.sv
sv/fat_chain_allocator_unit.sv
tb/sv/tb_top.sv
